// File: rtl/core/mdhs_pkg.sv
// Package for the max-depth hash set insert core.
// Holds the channel payload types, the queue entry type, the back-end state
// codes and the fixed key-mixing constants. No dependencies.
package mdhs_pkg;

  // Fixed field widths.
  localparam int KEY_W   = 32;
  localparam int DEPTH_W = 5;
  localparam int SLOT_W  = KEY_W + DEPTH_W;

  // Key-mixing constants.
  localparam int           MIX_SH_A = 15;
  localparam int           MIX_SH_B = 12;
  localparam int           MIX_SH_C = 2;
  localparam int           MIX_SH_D = 4;
  localparam logic [31:0]  MIX_MUL  = 32'd2057;
  localparam int           MIX_SH_E = 16;

  // Queue between the front end and the probe engine.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Input transaction payload.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [DEPTH_W-1:0] depth;
  } mdhs_in_t;

  // Result transaction payload.
  typedef struct packed {
    logic changed;
    logic was_new;
    logic load_high;
    logic refused;
  } mdhs_out_t;

  // One classified item waiting for the probe engine.
  typedef struct packed {
    logic               key_zero;
    logic [KEY_W-1:0]   key;
    logic [DEPTH_W-1:0] depth;
    logic [31:0]        mix;
  } mdhs_qitem_t;

  // Queue status seen by the probe engine and the top level.
  typedef struct packed {
    logic              empty;
    logic [QCNT_W-1:0] count;
  } mdhs_qstat_t;

  // Probe engine states.
  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_PROBE
  } mdhs_bstate_t;

endpackage

// File: rtl/core/max_depth_hash_set_insert_core.sv
// Top level of the max-depth hash set insert core.
// Uses mdhs_pkg, mdhs_front, mdhs_queue and mdhs_back.
//
// Usage:
//   Input channel: drive in_item (key, depth) and raise start; the transaction
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: one result per input, in input order, shown on out_item
//   for exactly one cycle with out_strobe high. The receiver cannot stall it.
// Flow:
//   A key of zero gives its result without a table access. Any other key
//   probes P slots of the table (at least 1), one slot-table read per cycle;
//   the probe engine takes no new item until it has finished the last one.
//   The front end and a 4-entry queue take new items while the engine
//   probes; busy rises when the queue has no room left.
// Reset:
//   After rst_n is released the slot table is cleared one slot per cycle,
//   with busy held high; occupancy starts at 0.
module max_depth_hash_set_insert_core
  import mdhs_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  mdhs_in_t  in_item,
  output logic      out_strobe,
  output mdhs_out_t out_item
);

  logic        take;
  logic        pending;
  logic        push;
  logic        pop;
  logic        clearing;
  mdhs_qitem_t push_item;
  mdhs_qitem_t head_item;
  mdhs_qstat_t qstat;

  // Hold off new transactions while clearing or when the queue could overflow.
  assign busy = clearing ||
                ((qstat.count + QCNT_W'(pending)) >= QCNT_W'(QUEUE_DEPTH));
  assign take = start && !busy;

  mdhs_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .in_item  (in_item),
    .pending  (pending),
    .push     (push),
    .push_item(push_item)
  );

  mdhs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head_item(head_item),
    .status   (qstat)
  );

  mdhs_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (head_item),
    .qstat     (qstat),
    .pop       (pop),
    .clearing  (clearing),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

endmodule

// File: rtl/core/mdhs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Uses no package.
module mdhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/mdhs_front.sv
// Front end: takes input transactions, mixes the key in two halves around
// one register stage and pushes classified items into the queue. Uses mdhs_pkg.
module mdhs_front
  import mdhs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  mdhs_in_t    in_item,
  output logic        pending,
  output logic        push,
  output mdhs_qitem_t push_item
);

  logic                s1_valid_r;
  logic [KEY_W-1:0]    s1_key_r;
  logic [DEPTH_W-1:0]  s1_depth_r;
  logic [31:0]         s1_mix_r;
  logic [31:0]         k1, k2, k3, k4, k5, k6;

  // First half of the mix: invert-add, xor-shift, add-shift.
  always_comb begin
    k1 = ~in_item.key + (in_item.key << MIX_SH_A);
    k2 = k1 ^ (k1 >> MIX_SH_B);
    k3 = k2 + (k2 << MIX_SH_C);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_key_r   <= in_item.key;
      s1_depth_r <= in_item.depth;
      s1_mix_r   <= k3;
    end
  end

  // Second half of the mix: xor-shift, constant multiply, final fold.
  always_comb begin
    k4 = s1_mix_r ^ (s1_mix_r >> MIX_SH_D);
    k5 = k4 * MIX_MUL;
    k6 = k5 ^ (k5 >> MIX_SH_E);
  end

  // The zero key is classified here so the probe engine skips the table.
  assign pending            = s1_valid_r;
  assign push               = s1_valid_r;
  assign push_item.key_zero = (s1_key_r == '0);
  assign push_item.key      = s1_key_r;
  assign push_item.depth    = s1_depth_r;
  assign push_item.mix      = k6;

endmodule

// File: rtl/core/mdhs_queue.sv
// Short queue between the front end and the probe engine.
// Uses mdhs_pkg for the entry type, depth and status struct.
module mdhs_queue
  import mdhs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  mdhs_qitem_t push_item,
  input  logic        pop,
  output mdhs_qitem_t head_item,
  output mdhs_qstat_t status
);

  mdhs_qitem_t       entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  // Occupancy tracking; the top level never pushes into a full queue.
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item    = entry_r[rd_ptr_r];
  assign status.empty = (count_r == '0);
  assign status.count = count_r;

endmodule

// File: rtl/core/mdhs_back.sv
// Probe engine: clears the slot table after reset, then takes queued items,
// probes the table linearly and updates keys, depths and occupancy.
// Uses mdhs_pkg and one mdhs_ram instance for the slot table.
module mdhs_back
  import mdhs_pkg::*;
#(
  parameter int TABLE_ENTRIES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mdhs_qitem_t head_item,
  input  mdhs_qstat_t qstat,
  output logic        pop,
  output logic        clearing,
  output logic        out_strobe,
  output mdhs_out_t   out_item
);

  localparam int              AW        = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0]   SlotMask  = AW'(TABLE_ENTRIES - 1);
  localparam logic [AW-1:0]   HalfTable = AW'(TABLE_ENTRIES / 2);

  mdhs_bstate_t        state_r, state_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [AW-1:0]       occ_r, occ_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic                strobe_r, strobe_nxt;
  mdhs_out_t           res_r, res_nxt;

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [SLOT_W-1:0]   ram_wdata, ram_rdata;
  logic [KEY_W-1:0]    rd_key;
  logic [DEPTH_W-1:0]  rd_depth;
  logic                hit_empty, hit_key;

  mdhs_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_key    = ram_rdata[SLOT_W-1:DEPTH_W];
  assign rd_depth  = ram_rdata[DEPTH_W-1:0];
  assign hit_empty = (rd_key == '0);
  assign hit_key   = (rd_key == key_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_CLEAR: begin
        if (clr_r == SlotMask) begin
          state_nxt = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!qstat.empty && !head_item.key_zero) begin
          state_nxt = B_PROBE;
        end
      end
      B_PROBE: begin
        if (hit_empty || hit_key) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_CLEAR;
    endcase
  end

  // Datapath, table access and result for each state.
  always_comb begin
    idx_nxt    = idx_r;
    key_nxt    = key_r;
    depth_nxt  = depth_r;
    occ_nxt    = occ_r;
    clr_nxt    = clr_r;
    strobe_nxt = 1'b0;
    res_nxt    = '0;
    pop        = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_wdata  = {key_r, depth_r};
    ram_raddr  = idx_r;
    case (state_r)
      B_CLEAR: begin
        // Sweep the table one slot per cycle, writing the empty marker.
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
      end
      B_IDLE: begin
        if (!qstat.empty) begin
          pop = 1'b1;
          if (head_item.key_zero) begin
            // The zero key never touches the table.
            strobe_nxt        = 1'b1;
            res_nxt.refused   = 1'b1;
            res_nxt.load_high = (occ_r >= HalfTable);
          end else begin
            idx_nxt   = head_item.mix[AW-1:0];
            key_nxt   = head_item.key;
            depth_nxt = head_item.depth;
            ram_raddr = head_item.mix[AW-1:0];
          end
        end
      end
      B_PROBE: begin
        if (hit_empty) begin
          // Absent key: store it unless only one free slot is left.
          strobe_nxt = 1'b1;
          if (occ_r < SlotMask) begin
            ram_we          = 1'b1;
            occ_nxt         = occ_r + 1'b1;
            res_nxt.changed = 1'b1;
            res_nxt.was_new = 1'b1;
          end else begin
            res_nxt.refused = 1'b1;
          end
          res_nxt.load_high = (occ_nxt >= HalfTable);
        end else if (hit_key) begin
          // Present key: raise the stored depth when the new one is larger.
          strobe_nxt = 1'b1;
          if (rd_depth < depth_r) begin
            ram_we          = 1'b1;
            res_nxt.changed = 1'b1;
          end
          res_nxt.load_high = (occ_r >= HalfTable);
        end else begin
          // Occupied by another key: step to the next slot with wraparound.
          idx_nxt   = idx_r + 1'b1;
          ram_raddr = idx_r + 1'b1;
        end
      end
      default: begin
        clr_nxt = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_CLEAR;
      clr_r    <= '0;
      occ_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      occ_r    <= occ_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    key_r   <= key_nxt;
    depth_r <= depth_nxt;
    res_r   <= res_nxt;
  end

  assign clearing   = (state_r == B_CLEAR);
  assign out_strobe = strobe_r;
  assign out_item   = res_r;

endmodule

// File: rtl/core/mdhs_check.sv
// Port-level checks for the max-depth hash set insert core, bound to the top.
// Uses mdhs_pkg for the payload types.
module mdhs_check
  import mdhs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input mdhs_in_t  in_item,
  input logic      out_strobe,
  input mdhs_out_t out_item
);

  // The table clear keeps the block busy right after reset.
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy) else $error("busy low right after reset");

  // No result appears right after reset.
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe) else $error("result strobe right after reset");

  // A newly stored key always counts as a change.
  a_new_is_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.was_new |-> out_item.changed)
    else $error("was_new without changed");

  // A refused transaction changes nothing.
  a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.refused |-> !out_item.changed && !out_item.was_new)
    else $error("refused result reports a change");

  // An accepted input transaction carries known values.
  a_take_known: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> !$isunknown(in_item))
    else $error("unknown input transaction accepted");

endmodule

bind max_depth_hash_set_insert_core mdhs_check u_check (.*);
